// ----- hdl/sm3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 package
// Shared types, constants and helper functions for the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [31:0] T_LOW    = 32'h79CC4519;
  localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
  // T_HIGH rotated left by 16, the constant used in round 16
  localparam logic [31:0] T_HIGH16 = {T_HIGH[15:0], T_HIGH[31:16]};
  localparam logic [31:0] PAD_WORD = 32'h80000000;

  localparam logic [31:0] SM3_IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  localparam logic [3:0] LEN_POS = 4'd14;

  typedef enum logic [1:0] {
    F_DATA,
    F_MARK,
    F_ZERO,
    F_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_RUN,
    B_OUT
  } back_state_t;

  // one block word handed from front to back
  typedef struct packed {
    logic        last_blk;
    logic [31:0] data;
  } sm3_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    rotl32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    perm0 = x ^ rotl32(x, 9) ^ rotl32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    perm1 = x ^ rotl32(x, 15) ^ rotl32(x, 23);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sm3_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 channel interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic [2:0]  valid_bytes;
  logic        end_of_message;

  modport source (output valid, msg_word, valid_bytes, end_of_message, input ready);
  modport sink   (input valid, msg_word, valid_bytes, end_of_message, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_done;

  modport source (output valid, digest_word, digest_index, digest_done, input ready);
  modport sink   (input valid, digest_word, digest_index, digest_done, output ready);
endinterface
`default_nettype wire

// ----- hdl/sm3_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 front end
// Takes message words, counts bytes and appends padding and bit length.
// ----------------------------------------------------------------------------
module sm3_front
  import sm3_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  sm3_in_if.sink          in_ch,
  input  wire fifo_stat_t stat,
  output logic            push,
  output sm3_word_t       push_word
);

  front_state_t state_r, state_nxt;
  logic [3:0]   pos_r, pos_nxt;
  logic [60:0]  total_r, total_nxt;
  logic [60:0]  len_r, len_nxt;
  logic [2:0]   nbytes;
  logic [31:0]  keep_mask, pad_bits;

  // clamp byte count of a final word
  assign nbytes = (in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;

  always_comb begin
    unique case (nbytes)
      3'd0:    begin keep_mask = 32'h00000000; pad_bits = 32'h80000000; end
      3'd1:    begin keep_mask = 32'hFF000000; pad_bits = 32'h00800000; end
      3'd2:    begin keep_mask = 32'hFFFF0000; pad_bits = 32'h00008000; end
      3'd3:    begin keep_mask = 32'hFFFFFF00; pad_bits = 32'h00000080; end
      default: begin keep_mask = 32'hFFFFFFFF; pad_bits = 32'h00000000; end
    endcase
  end

  always_comb begin
    state_nxt          = state_r;
    pos_nxt            = pos_r;
    total_nxt          = total_r;
    len_nxt            = len_r;
    push               = 1'b0;
    push_word.last_blk = 1'b0;
    push_word.data     = '0;
    in_ch.ready        = 1'b0;
    unique case (state_r)
      F_DATA: begin
        in_ch.ready = !stat.full;
        if (in_ch.valid && !stat.full) begin
          push = 1'b1;
          if (!in_ch.end_of_message) begin
            push_word.data = in_ch.msg_word;
            total_nxt      = total_r + 61'd4;
          end else if (nbytes == 3'd4) begin
            push_word.data = in_ch.msg_word;
            len_nxt        = total_r + 61'd4;
            total_nxt      = '0;
            state_nxt      = F_MARK;
          end else begin
            push_word.data = (in_ch.msg_word & keep_mask) | pad_bits;
            len_nxt        = total_r + {58'd0, nbytes};
            total_nxt      = '0;
            state_nxt      = F_ZERO;
          end
        end
      end
      F_MARK: begin
        if (!stat.full) begin
          push           = 1'b1;
          push_word.data = PAD_WORD;
          state_nxt      = F_ZERO;
        end
      end
      F_ZERO: begin
        if (!stat.full) begin
          push = 1'b1;
          if (pos_r == LEN_POS) begin
            push_word.data = len_r[60:29];
            state_nxt      = F_LEN;
          end
        end
      end
      F_LEN: begin
        if (!stat.full) begin
          push               = 1'b1;
          push_word.data     = {len_r[28:0], 3'b000};
          push_word.last_blk = 1'b1;
          state_nxt          = F_DATA;
        end
      end
      default: state_nxt = F_DATA;
    endcase
    if (push) pos_nxt = pos_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_DATA;
      pos_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
    end
    len_r <= len_nxt;
  end

endmodule
`default_nettype wire

// ----- hdl/sm3_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 word queue
// Short register queue of block words between front and back.
// ----------------------------------------------------------------------------
module sm3_fifo
  import sm3_pkg::*;
#(
  parameter int Depth = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire sm3_word_t push_word,
  input  wire logic      pop,
  output sm3_word_t      pop_word,
  output fifo_stat_t     stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sm3_word_t       mem [Depth];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [CntW-1:0] cnt_r;

  assign stat.full  = (cnt_r == CntW'(Depth));
  assign stat.empty = (cnt_r == '0);
  assign pop_word   = mem[rd_r];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_word;
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= bump(wr_r);
      if (pop)  rd_r <= bump(rd_r);
      if (push && !pop)      cnt_r <= cnt_r + CntW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CntW'(1);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sm3_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 compression core
// Loads block words, runs 64 rounds one per cycle, sends out the digest.
// ----------------------------------------------------------------------------
module sm3_core
  import sm3_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire fifo_stat_t stat,
  input  wire sm3_word_t  pop_word,
  output logic            pop,
  sm3_out_if.source       out_ch
);

  back_state_t state_r, state_nxt;
  logic [31:0] w_r    [16];
  logic [31:0] work_r [8];
  logic [31:0] cv_r   [8];
  logic [5:0]  rnd_r;
  logic [3:0]  cnt_r;
  logic [2:0]  idx_r;
  logic        blk_last_r;
  logic [31:0] t_r;

  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
  logic        load_done, run_done, out_take;

  // round datapath
  always_comb begin
    a12 = rotl32(work_r[0], 12);
    ss1 = rotl32(a12 + work_r[4] + t_r, 7);
    ss2 = ss1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = work_r[0] ^ work_r[1] ^ work_r[2];
      gg = work_r[4] ^ work_r[5] ^ work_r[6];
    end else begin
      ff = (work_r[0] & work_r[1]) | (work_r[0] & work_r[2]) | (work_r[1] & work_r[2]);
      gg = (work_r[4] & work_r[5]) | (~work_r[4] & work_r[6]);
    end
    tt1   = ff + work_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2   = gg + work_r[7] + ss1 + w_r[0];
    w_new = perm1(w_r[0] ^ w_r[7] ^ rotl32(w_r[13], 15)) ^ rotl32(w_r[3], 7) ^ w_r[10];
  end

  always_comb begin
    state_nxt           = state_r;
    pop                 = 1'b0;
    out_ch.valid        = 1'b0;
    out_ch.digest_word  = cv_r[idx_r];
    out_ch.digest_index = idx_r;
    out_ch.digest_done  = (idx_r == 3'd7);
    load_done           = 1'b0;
    run_done            = 1'b0;
    out_take            = 1'b0;
    unique case (state_r)
      B_LOAD: begin
        pop = !stat.empty;
        if (pop && cnt_r == 4'd15) begin
          load_done = 1'b1;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (rnd_r == 6'd63) begin
          run_done  = 1'b1;
          state_nxt = blk_last_r ? B_OUT : B_LOAD;
        end
      end
      B_OUT: begin
        out_ch.valid = 1'b1;
        out_take     = out_ch.ready;
        if (out_take && idx_r == 3'd7) state_nxt = B_LOAD;
      end
      default: state_nxt = B_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_LOAD;
      cnt_r   <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        cv_r[i]   <= SM3_IV[i];
        work_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        cnt_r <= cnt_r + 4'd1;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= pop_word.data;
        if (cnt_r == 4'd15) blk_last_r <= pop_word.last_blk;
      end
      if (load_done) begin
        rnd_r <= '0;
        t_r   <= T_LOW;
        for (int i = 0; i < 8; i++) work_r[i] <= cv_r[i];
      end
      if (state_r == B_RUN) begin
        rnd_r <= rnd_r + 6'd1;
        t_r   <= (rnd_r == 6'd15) ? T_HIGH16 : rotl32(t_r, 1);
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15]   <= w_new;
        work_r[0] <= tt1;
        work_r[1] <= work_r[0];
        work_r[2] <= rotl32(work_r[1], 9);
        work_r[3] <= work_r[2];
        work_r[4] <= perm0(tt2);
        work_r[5] <= work_r[4];
        work_r[6] <= rotl32(work_r[5], 19);
        work_r[7] <= work_r[6];
      end
      if (run_done) begin
        idx_r   <= '0;
        cv_r[0] <= cv_r[0] ^ tt1;
        cv_r[1] <= cv_r[1] ^ work_r[0];
        cv_r[2] <= cv_r[2] ^ rotl32(work_r[1], 9);
        cv_r[3] <= cv_r[3] ^ work_r[2];
        cv_r[4] <= cv_r[4] ^ perm0(tt2);
        cv_r[5] <= cv_r[5] ^ work_r[4];
        cv_r[6] <= cv_r[6] ^ rotl32(work_r[5], 19);
        cv_r[7] <= cv_r[7] ^ work_r[6];
      end
      if (out_take) begin
        idx_r <= idx_r + 3'd1;
        // back to the IV once the last digest word leaves
        if (idx_r == 3'd7) begin
          for (int i = 0; i < 8; i++) cv_r[i] <= SM3_IV[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sm3_hash_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 hash engine
// 256-bit SM3 digest of a message streamed as big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Feed the message as big-endian words on in_ch, first byte in bits 31:24;
// every word but the last counts as four bytes, and the word flagged
// end_of_message carries 0 to 4 valid bytes. The engine pads the message,
// appends the 64-bit bit length and returns the digest as eight words on
// out_ch, index 0 first, with digest_done on index 7; then it starts over
// from the IV for the next message. The back end runs one compression round
// per cycle: each 64-byte block is loaded as sixteen words into the
// expansion window, then the 64 rounds run, and a message end adds the
// padding blocks and the eight digest words. The front end keeps taking
// words into a short queue while the core is busy, until the queue is full.
module sm3_hash_engine
  import sm3_pkg::*;
#(
  parameter int FifoDepth = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  // front to queue
  logic       push;
  sm3_word_t  push_word;
  // queue to core
  logic       pop;
  sm3_word_t  pop_word;
  fifo_stat_t stat;

  // accept words, append padding and length
  sm3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .stat      (stat),
    .push      (push),
    .push_word (push_word)
  );

  // decouple front and core
  sm3_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .stat      (stat)
  );

  // compress blocks and send the digest
  sm3_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .pop_word (pop_word),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // never write a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("push into full word queue");

  // never read an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("pop from empty word queue");

  // done flag marks exactly the last digest word
  a_done_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.digest_done == (out_ch.digest_index == 3'd7)))
    else $error("digest_done out of step with digest_index");

endmodule
`default_nettype wire
